// ===== rtl/core/path_command_absolute_transform_macros.svh =====
// ----------------------------------------------------------------------------
// Path command transform assertion macros
// Concurrent checks that sample on clk_i and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PATH_COMMAND_ABSOLUTE_TRANSFORM_MACROS_SVH
`define PATH_COMMAND_ABSOLUTE_TRANSFORM_MACROS_SVH

// same-cycle implication
`define PCAT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/pcat_pkg.sv =====
// ----------------------------------------------------------------------------
// Path command transform package
// Shared widths, command letters, register indexes, lane control and helpers.
// ----------------------------------------------------------------------------
package pcat_pkg;

  localparam int unsigned MAX_ARGS = 6;
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned ROT_BITS = 14;
  localparam int unsigned SCALE_W  = 24;
  localparam int unsigned TRIG_W   = 16;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned CMD_W    = 7;
  localparam int unsigned CFG_W    = 24;
  localparam int unsigned IDX_W    = 2;

  localparam logic [CMD_W-1:0] CMD_M_REL   = 7'h6d;
  localparam logic [CMD_W-1:0] CMD_L_REL   = 7'h6c;
  localparam logic [CMD_W-1:0] CMD_Q_REL   = 7'h71;
  localparam logic [CMD_W-1:0] CMD_T_REL   = 7'h74;
  localparam logic [CMD_W-1:0] CMD_C_REL   = 7'h63;
  localparam logic [CMD_W-1:0] CMD_S_REL   = 7'h73;
  localparam logic [CMD_W-1:0] CMD_Z_REL   = 7'h7a;
  localparam logic [CMD_W-1:0] CMD_V_REL   = 7'h76;
  localparam logic [CMD_W-1:0] CMD_V_ABS   = 7'h56;
  localparam logic [CMD_W-1:0] CMD_H_REL   = 7'h68;
  localparam logic [CMD_W-1:0] CMD_H_ABS   = 7'h48;
  localparam logic [CMD_W-1:0] CMD_L_ABS   = 7'h4c;
  localparam logic [CMD_W-1:0] CASE_OFFSET = 7'h20;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [IDX_W-1:0] {
    REG_SCALE  = 2'd0,
    REG_ROT_EN = 2'd1,
    REG_COS    = 2'd2,
    REG_SIN    = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic load;
    logic clear_pen;
    logic step;
    logic commit;
    logic rot_mul;
  } lane_ctrl_t;

  function automatic coord_t sat32(input logic signed [63:0] v);
    coord_t r;
    if (v > 64'sh0000_0000_7fff_ffff) begin
      r = 32'sh7fff_ffff;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic is_pair_cmd(input logic [CMD_W-1:0] c);
    return (c == CMD_M_REL) || (c == CMD_L_REL) || (c == CMD_Q_REL) ||
           (c == CMD_T_REL) || (c == CMD_C_REL) || (c == CMD_S_REL) ||
           (c == CMD_Z_REL);
  endfunction

  function automatic logic is_hv_cmd(input logic [CMD_W-1:0] c);
    return (c == CMD_H_REL) || (c == CMD_H_ABS) || (c == CMD_V_REL) || (c == CMD_V_ABS);
  endfunction

endpackage

// ===== rtl/core/pcat_lane.sv =====
// ----------------------------------------------------------------------------
// Path command transform lane
// One coordinate pair: scale on load, pen offset, and two-step rotation.
// ----------------------------------------------------------------------------
module pcat_lane import pcat_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  lane_ctrl_t          ctrl_i,
  input  logic [SCALE_W-1:0]  scale_i,
  input  logic signed [TRIG_W-1:0] cos_i,
  input  logic signed [TRIG_W-1:0] sin_i,
  input  coord_t              arg_x_i,
  input  coord_t              arg_y_i,
  input  coord_t              pen_x_i,
  input  coord_t              pen_y_i,
  input  coord_t              res_x_i,
  input  coord_t              res_y_i,
  input  logic                rot_i,
  output coord_t              a_x_o,
  output coord_t              a_y_o,
  output coord_t              off_x_o,
  output coord_t              off_y_o,
  output coord_t              fin_x_o,
  output coord_t              fin_y_o
);

  localparam int unsigned PROD_W = COORD_W + SCALE_W + 1;
  localparam int unsigned ROTP_W = COORD_W + TRIG_W;

  logic signed [PROD_W-1:0] prod_x, prod_y, shs_x, shs_y;
  coord_t scaled_x, scaled_y;
  coord_t a_x_q, a_y_q;
  logic rot_q;
  logic signed [ROTP_W-1:0] cx_q, sy_q, sx_q, cy_q;
  logic signed [ROTP_W:0] sum_x, sum_y, shr_x, shr_y;

  assign prod_x   = arg_x_i * $signed({1'b0, scale_i});
  assign prod_y   = arg_y_i * $signed({1'b0, scale_i});
  assign shs_x    = prod_x >>> FRAC_BITS;
  assign shs_y    = prod_y >>> FRAC_BITS;
  assign scaled_x = sat32(64'(shs_x));
  assign scaled_y = sat32(64'(shs_y));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      a_x_q <= (scale_i != '0) ? scaled_x : arg_x_i;
      a_y_q <= (scale_i != '0) ? scaled_y : arg_y_i;
    end else if (ctrl_i.commit) begin
      a_x_q <= res_x_i;
      a_y_q <= res_y_i;
      rot_q <= rot_i;
    end
    if (ctrl_i.rot_mul) begin
      cx_q <= cos_i * a_x_q;
      sy_q <= sin_i * a_y_q;
      sx_q <= sin_i * a_x_q;
      cy_q <= cos_i * a_y_q;
    end
  end

  assign off_x_o = sat32(64'(a_x_q) + 64'(pen_x_i));
  assign off_y_o = sat32(64'(a_y_q) + 64'(pen_y_i));
  assign a_x_o   = a_x_q;
  assign a_y_o   = a_y_q;

  assign sum_x = (ROTP_W+1)'(cx_q) - (ROTP_W+1)'(sy_q);
  assign sum_y = (ROTP_W+1)'(sx_q) + (ROTP_W+1)'(cy_q);
  assign shr_x = sum_x >>> ROT_BITS;
  assign shr_y = sum_y >>> ROT_BITS;

  assign fin_x_o = rot_q ? sat32(64'(shr_x)) : a_x_q;
  assign fin_y_o = rot_q ? sat32(64'(shr_y)) : a_y_q;

endmodule

// ===== rtl/core/pcat_merge.sv =====
// ----------------------------------------------------------------------------
// Path command transform merge stage
// Combines lane values into the converted command, walks relative H/V
// arguments, and holds the pen position.
// ----------------------------------------------------------------------------
module pcat_merge import pcat_pkg::*; #(
  parameter int unsigned NARGS = 6
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lane_ctrl_t              ctrl_i,
  input  logic [CMD_W-1:0]        cmd_i,
  input  logic [CNT_W-1:0]        n_i,
  input  logic                    rot_en_i,
  input  coord_t [NARGS-1:0]      a_i,
  input  coord_t [NARGS-1:0]      off_i,
  output coord_t                  pen_x_o,
  output coord_t                  pen_y_o,
  output coord_t [NARGS-1:0]      res_o,
  output logic [NARGS/2-1:0]      rot_o,
  output logic                    done_o,
  output logic [CMD_W-1:0]        cmd_o,
  output logic [CNT_W-1:0]        cnt_o
);

  localparam int unsigned NPAIRS = NARGS / 2;
  localparam int unsigned IW     = $clog2(NARGS);

  coord_t pen_x_q, pen_y_q, acc_q;
  logic [CNT_W-1:0] idx_q, cnt_q;
  logic [CMD_W-1:0] cmd_q;

  logic is_pair, is_hv, horiz, rel_hv;
  logic [CNT_W-1:0] sel_addr, cnt;
  coord_t a_sel, pen_sel, acc_base, acc_d, hv_val, pen_x_d, pen_y_d, base;
  logic [CMD_W-1:0] cmd_d;

  always_comb begin
    is_pair  = is_pair_cmd(cmd_i);
    is_hv    = is_hv_cmd(cmd_i);
    horiz    = (cmd_i == CMD_H_REL) || (cmd_i == CMD_H_ABS);
    rel_hv   = (cmd_i == CMD_H_REL) || (cmd_i == CMD_V_REL);
    sel_addr = rel_hv ? idx_q : (n_i - 3'd1);
    a_sel    = a_i[sel_addr[IW-1:0]];
    pen_sel  = horiz ? pen_x_q : pen_y_q;
    acc_base = (idx_q == '0) ? pen_sel : acc_q;
    acc_d    = sat32(64'(acc_base) + 64'(a_sel));
    if (n_i == '0) begin
      hv_val = pen_sel;
    end else begin
      hv_val = rel_hv ? acc_q : a_sel;
    end
    done_o = !rel_hv || (idx_q == n_i);
    cnt    = is_hv ? 3'd2 : n_i;

    res_o = '0;
    for (int i = 0; i < NARGS; i++) begin
      base = (is_pair && (3'(i >> 1) < (n_i >> 1))) ? off_i[i] : a_i[i];
      if (3'(i) < cnt) begin
        res_o[i] = base;
      end
    end
    if (is_hv) begin
      res_o    = '0;
      res_o[0] = horiz ? hv_val : pen_x_q;
      res_o[1] = horiz ? pen_y_q : hv_val;
    end

    pen_x_d = pen_x_q;
    pen_y_d = pen_y_q;
    if (cnt >= 3'd2) begin
      for (int i = 0; i < NARGS - 1; i++) begin
        if (3'(i) == (cnt - 3'd2)) begin
          pen_x_d = res_o[i];
          pen_y_d = res_o[i+1];
        end
      end
    end

    for (int p = 0; p < NPAIRS; p++) begin
      rot_o[p] = rot_en_i && (3'(p) < (cnt >> 1));
    end

    if (is_pair) begin
      cmd_d = cmd_i - CASE_OFFSET;
    end else if (is_hv) begin
      cmd_d = CMD_L_ABS;
    end else begin
      cmd_d = cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q <= '0;
      pen_y_q <= '0;
      idx_q   <= '0;
    end else begin
      if (ctrl_i.load) begin
        idx_q <= '0;
        if (ctrl_i.clear_pen) begin
          pen_x_q <= '0;
          pen_y_q <= '0;
        end
      end else if (ctrl_i.step && !done_o) begin
        idx_q <= idx_q + 3'd1;
      end else if (ctrl_i.commit) begin
        pen_x_q <= pen_x_d;
        pen_y_q <= pen_y_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step && !done_o) begin
      acc_q <= acc_d;
    end
    if (ctrl_i.commit) begin
      cmd_q <= cmd_d;
      cnt_q <= cnt;
    end
  end

  assign pen_x_o = pen_x_q;
  assign pen_y_o = pen_y_q;
  assign cmd_o   = cmd_q;
  assign cnt_o   = cnt_q;

endmodule

// ===== rtl/core/path_command_absolute_transform.sv =====
// ----------------------------------------------------------------------------
// Path command transform top level
// Converts relative path commands to absolute, with optional scale and
// rotation, and keeps the pen position between commands.
// ----------------------------------------------------------------------------
// One command at a time. A command passes from acceptance to a loaded output
// register in steps: scale on the accept edge, a merge state, a rotation
// multiply state and a rotation sum state that loads the output once it is free.
// Relative h and v commands repeat the merge step for each argument, since their
// saturating sum walks the arguments through a single adder. The next command is taken while
// a finished result waits in the output register; the pipeline stalls only
// when a second result is ready before the first is taken.
`include "path_command_absolute_transform_macros.svh"

module path_command_absolute_transform import pcat_pkg::*; #(
  parameter int unsigned COORD_PAIRS = 3,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                path_start_i,
  input  logic [CMD_W-1:0]    mode_i,
  input  logic [CNT_W-1:0]    arg_count_i,
  input  coord_t              arg0_i,
  input  coord_t              arg1_i,
  input  coord_t              arg2_i,
  input  coord_t              arg3_i,
  input  coord_t              arg4_i,
  input  coord_t              arg5_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CMD_W-1:0]    out_command_o,
  output logic [CNT_W-1:0]    out_count_o,
  output coord_t              out0_o,
  output coord_t              out1_o,
  output coord_t              out2_o,
  output coord_t              out3_o,
  output coord_t              out4_o,
  output coord_t              out5_o
);

  localparam int unsigned NARGS  = (2 * COORD_PAIRS > MAX_ARGS) ? MAX_ARGS : 2 * COORD_PAIRS;
  localparam int unsigned NPAIRS = NARGS / 2;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MERGE = 4'b0010,
    ST_RMUL  = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [SCALE_W-1:0]      scale_q;
  logic                    rot_en_q;
  logic signed [TRIG_W-1:0] cos_q, sin_q;

  logic [CMD_W-1:0] cmd_q;
  logic [CNT_W-1:0] n_q;

  lane_ctrl_t ctrl;
  logic accept, out_free, load_out, done;

  coord_t [MAX_ARGS-1:0] in_args;
  coord_t [NARGS-1:0]    a_all, off_all, res_all, fin_all;
  coord_t [MAX_ARGS-1:0] fin_ext;
  logic [NPAIRS-1:0]     rot_all;
  coord_t pen_x, pen_y;
  logic [CMD_W-1:0] m_cmd;
  logic [CNT_W-1:0] m_cnt;

  logic                  out_valid_q;
  logic [CMD_W-1:0]      out_cmd_q;
  logic [CNT_W-1:0]      out_cnt_q;
  coord_t [MAX_ARGS-1:0] out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= '0;
      rot_en_q <= 1'b0;
      cos_q    <= 16'sd16384;
      sin_q    <= '0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_SCALE:  scale_q  <= cfg_data_i[SCALE_W-1:0];
        REG_ROT_EN: rot_en_q <= cfg_data_i[0];
        REG_COS:    cos_q    <= cfg_data_i[TRIG_W-1:0];
        REG_SIN:    sin_q    <= cfg_data_i[TRIG_W-1:0];
        default:    scale_q  <= scale_q;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign load_out   = (state_q == ST_OUT) && out_free;

  always_comb begin
    ctrl.load      = accept;
    ctrl.clear_pen = accept && path_start_i;
    ctrl.step      = (state_q == ST_MERGE);
    ctrl.commit    = (state_q == ST_MERGE) && done;
    ctrl.rot_mul   = (state_q == ST_RMUL);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_MERGE;
      ST_MERGE: if (done) state_d = ST_RMUL;
      ST_RMUL:  state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= mode_i;
      n_q   <= (arg_count_i > CNT_W'(NARGS)) ? CNT_W'(NARGS) : arg_count_i;
    end
  end

  assign in_args = {arg5_i, arg4_i, arg3_i, arg2_i, arg1_i, arg0_i};

  for (genvar p = 0; p < NPAIRS; p++) begin : g_lane
    pcat_lane #(
      .FRAC_BITS(FRAC_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .scale_i (scale_q),
      .cos_i   (cos_q),
      .sin_i   (sin_q),
      .arg_x_i (in_args[2*p]),
      .arg_y_i (in_args[2*p+1]),
      .pen_x_i (pen_x),
      .pen_y_i (pen_y),
      .res_x_i (res_all[2*p]),
      .res_y_i (res_all[2*p+1]),
      .rot_i   (rot_all[p]),
      .a_x_o   (a_all[2*p]),
      .a_y_o   (a_all[2*p+1]),
      .off_x_o (off_all[2*p]),
      .off_y_o (off_all[2*p+1]),
      .fin_x_o (fin_all[2*p]),
      .fin_y_o (fin_all[2*p+1])
    );
  end

  pcat_merge #(
    .NARGS(NARGS)
  ) u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .cmd_i    (cmd_q),
    .n_i      (n_q),
    .rot_en_i (rot_en_q),
    .a_i      (a_all),
    .off_i    (off_all),
    .pen_x_o  (pen_x),
    .pen_y_o  (pen_y),
    .res_o    (res_all),
    .rot_o    (rot_all),
    .done_o   (done),
    .cmd_o    (m_cmd),
    .cnt_o    (m_cnt)
  );

  always_comb begin
    fin_ext = '0;
    for (int i = 0; i < NARGS; i++) begin
      fin_ext[i] = fin_all[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_cmd_q <= m_cmd;
      out_cnt_q <= m_cnt;
      out_q     <= fin_ext;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_command_o = out_cmd_q;
  assign out_count_o   = out_cnt_q;
  assign out0_o        = out_q[0];
  assign out1_o        = out_q[1];
  assign out2_o        = out_q[2];
  assign out3_o        = out_q[3];
  assign out4_o        = out_q[4];
  assign out5_o        = out_q[5];

  `PCAT_ASSERT_NEXT(a_accept_to_merge, in_valid_i && in_ready_o, state_q == ST_MERGE, "accepted transaction did not enter merge")
  `PCAT_ASSERT_NOW(a_count_limit, out_valid_o, out_count_o <= CNT_W'(NARGS), "output count above lane limit")
  `PCAT_ASSERT_NOW(a_empty_zero, out_valid_o && out_count_o == '0, out0_o == '0 && out1_o == '0, "coordinates beyond count not zero")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Path command transform testbench
// Streams parsed path commands through the block under several register
// settings and checks every result against a scoreboard that tracks the pen
// and converts relative commands to absolute, with scaling and rotation.
// ----------------------------------------------------------------------------
module tb_top;
  import pcat_pkg::*;

  localparam int unsigned COORD_PAIRS  = 3;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned ARG_LIMIT    = (2 * COORD_PAIRS > MAX_ARGS) ? MAX_ARGS
                                                                      : 2 * COORD_PAIRS;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned IDLE_PCT     = 30;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_PRINTS   = 40;

  localparam longint PEN_MAX = 64'sd2147483647;
  localparam longint PEN_MIN = -64'sd2147483648;
  localparam longint COS_RESET = 64'sd16384;

  localparam coord_t COORD_MAX = 32'sh7fff_ffff;
  localparam coord_t COORD_MIN = 32'sh8000_0000;
  localparam coord_t UNIT      = 32'sh0001_0000;

  localparam logic [CMD_W-1:0] CMD_M_ABS = 7'h4d;
  localparam logic [CMD_W-1:0] CMD_C_ABS = 7'h43;
  localparam logic [CMD_W-1:0] CMD_A_REL = 7'h61;
  localparam logic [CMD_W-1:0] CMD_Z_ABS = 7'h5a;
  localparam logic [CMD_W-1:0] CMD_NUL   = 7'h00;
  localparam logic [CMD_W-1:0] CMD_DEL   = 7'h7f;

  typedef struct {
    logic             path_start;
    logic [CMD_W-1:0] mode;
    logic [CNT_W-1:0] count;
    coord_t           args [MAX_ARGS];
  } path_cmd_t;

  typedef struct {
    logic [CMD_W-1:0] command;
    logic [CNT_W-1:0] count;
    coord_t           coords [MAX_ARGS];
  } path_result_t;

  class path_scoreboard;
    logic [SCALE_W-1:0] scale;
    bit                 rot_en;
    longint             cos_v;
    longint             sin_v;
    longint             pen_x;
    longint             pen_y;
    path_result_t       absolute_q [$];
    int unsigned        errors;
    int unsigned        compared;

    function new();
      scale    = '0;
      rot_en   = 1'b0;
      cos_v    = COS_RESET;
      sin_v    = 0;
      pen_x    = 0;
      pen_y    = 0;
      errors   = 0;
      compared = 0;
    endfunction

    static function longint clamp32(longint v);
      if (v > PEN_MAX) return PEN_MAX;
      if (v < PEN_MIN) return PEN_MIN;
      return v;
    endfunction

    function int unsigned pending();
      return absolute_q.size();
    endfunction

    function void set_reg(reg_idx_e idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_SCALE:  scale = data[SCALE_W-1:0];
        REG_ROT_EN: rot_en = data[0];
        REG_COS:    cos_v = longint'($signed(data[TRIG_W-1:0]));
        REG_SIN:    sin_v = longint'($signed(data[TRIG_W-1:0]));
        default: ;
      endcase
    endfunction

    function void add_command(path_cmd_t c);
      longint           a [MAX_ARGS];
      longint           r [MAX_ARGS];
      longint           val;
      longint           x;
      longint           y;
      int unsigned      n;
      int unsigned      cnt;
      int unsigned      i;
      logic [CMD_W-1:0] cmd;
      bit               horiz;
      bit               rel;
      path_result_t     e;
      n = c.count;
      if (n > ARG_LIMIT) n = ARG_LIMIT;
      cmd = c.mode;
      if (c.path_start) begin
        pen_x = 0;
        pen_y = 0;
      end
      for (i = 0; i < MAX_ARGS; i++) begin
        a[i] = longint'(c.args[i]);
        if (scale != 0) a[i] = clamp32((a[i] * longint'(scale)) >>> FRAC_BITS);
      end
      cnt = n;
      case (cmd)
        CMD_M_REL, CMD_L_REL, CMD_Q_REL, CMD_T_REL, CMD_C_REL, CMD_S_REL,
        CMD_Z_REL: begin
          for (i = 0; i < n / 2; i++) begin
            a[2*i]   = clamp32(a[2*i] + pen_x);
            a[2*i+1] = clamp32(a[2*i+1] + pen_y);
          end
          cmd = cmd - CASE_OFFSET;
        end
        CMD_H_REL, CMD_H_ABS, CMD_V_REL, CMD_V_ABS: begin
          horiz = (cmd == CMD_H_REL) || (cmd == CMD_H_ABS);
          rel   = (cmd == CMD_H_REL) || (cmd == CMD_V_REL);
          val   = horiz ? pen_x : pen_y;
          if (n > 0) begin
            if (rel) begin
              for (i = 0; i < n; i++) val = clamp32(val + a[i]);
            end else begin
              val = a[n-1];
            end
          end
          a[0] = horiz ? val : pen_x;
          a[1] = horiz ? pen_y : val;
          cnt  = 2;
          cmd  = CMD_L_ABS;
        end
        default: ;
      endcase
      for (i = 0; i < MAX_ARGS; i++) r[i] = (i < cnt) ? a[i] : 0;
      if (cnt >= 2) begin
        pen_x = r[cnt-2];
        pen_y = r[cnt-1];
      end
      if (rot_en) begin
        for (i = 0; i < cnt / 2; i++) begin
          x        = r[2*i];
          y        = r[2*i+1];
          r[2*i]   = clamp32((cos_v * x - sin_v * y) >>> ROT_BITS);
          r[2*i+1] = clamp32((sin_v * x + cos_v * y) >>> ROT_BITS);
        end
      end
      e.command = cmd;
      e.count   = CNT_W'(cnt);
      for (i = 0; i < MAX_ARGS; i++) e.coords[i] = coord_t'(r[i]);
      absolute_q.insert(absolute_q.size(), e);
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTS) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(path_result_t got);
      path_result_t want;
      int           i;
      if (absolute_q.size() == 0) begin
        report_mismatch($sformatf("result with command %02h and nothing pending",
                                  got.command));
        return;
      end
      want = absolute_q.pop_front();
      compared++;
      if (got.command !== want.command)
        report_mismatch($sformatf("result %0d command %02h, want %02h", compared,
                                  got.command, want.command));
      if (got.count !== want.count)
        report_mismatch($sformatf("result %0d count %0d, want %0d", compared,
                                  got.count, want.count));
      for (i = 0; i < MAX_ARGS; i++) begin
        if (got.coords[i] !== want.coords[i])
          report_mismatch($sformatf("result %0d coord %0d %08h, want %08h", compared, i,
                                    got.coords[i], want.coords[i]));
      end
    endtask
  endclass

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             cfg_valid  = 1'b0;
  logic [IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0] cfg_data   = '0;
  logic             in_valid   = 1'b0;
  logic             path_start = 1'b0;
  logic [CMD_W-1:0] mode       = '0;
  logic [CNT_W-1:0] arg_count  = '0;
  coord_t           arg [MAX_ARGS] = '{default: '0};
  logic             out_ready  = 1'b0;
  logic             quiet      = 1'b0;

  logic             cfg_ready;
  logic             in_ready;
  logic             out_valid;
  logic [CMD_W-1:0] out_command;
  logic [CNT_W-1:0] out_count;
  coord_t           out_coord [MAX_ARGS];

  path_scoreboard   sb;
  int unsigned      sent     = 0;
  int unsigned      settings = 1;
  int unsigned      cycles   = 0;

  path_command_absolute_transform #(
    .COORD_PAIRS(COORD_PAIRS),
    .FRAC_BITS  (FRAC_BITS)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .path_start_i (path_start),
    .mode_i       (mode),
    .arg_count_i  (arg_count),
    .arg0_i       (arg[0]),
    .arg1_i       (arg[1]),
    .arg2_i       (arg[2]),
    .arg3_i       (arg[3]),
    .arg4_i       (arg[4]),
    .arg5_i       (arg[5]),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_command_o(out_command),
    .out_count_o  (out_count),
    .out0_o       (out_coord[0]),
    .out1_o       (out_coord[1]),
    .out2_o       (out_coord[2]),
    .out3_o       (out_coord[3]),
    .out4_o       (out_coord[4]),
    .out5_o       (out_coord[5])
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending", cycles, sb.pending());
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    path_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.command = out_command;
      got.count   = out_count;
      for (int k = 0; k < MAX_ARGS; k++) got.coords[k] = out_coord[k];
      sb.check_result(got);
    end
    out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic path_cmd_t mk(input logic start, input logic [CMD_W-1:0] m,
                                   input logic [CNT_W-1:0] n, input coord_t a0,
                                   input coord_t a1, input coord_t a2, input coord_t a3,
                                   input coord_t a4, input coord_t a5);
    path_cmd_t c;
    c.path_start = start;
    c.mode       = m;
    c.count      = n;
    c.args[0]    = a0;
    c.args[1]    = a1;
    c.args[2]    = a2;
    c.args[3]    = a3;
    c.args[4]    = a4;
    c.args[5]    = a5;
    return c;
  endfunction

  function automatic coord_t rand_coord();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) return coord_t'($urandom_range(32'h001f_ffff)) - 32'sh0010_0000;
    if (pick < 60) return coord_t'($urandom_range(32'h1fff_ffff)) - 32'sh1000_0000;
    if (pick < 85) return coord_t'($urandom());
    case ($urandom_range(3))
      0:       return COORD_MAX;
      1:       return COORD_MIN;
      2:       return '0;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic path_cmd_t rand_cmd(input bit fresh);
    path_cmd_t   c;
    int unsigned want;
    int unsigned i;
    c.path_start = fresh || ($urandom_range(19) == 0);
    want = 2;
    if (fresh) begin
      c.mode = ($urandom_range(1) == 0) ? CMD_M_REL : CMD_M_ABS;
    end else begin
      case ($urandom_range(19))
        0:        c.mode = CMD_M_REL;
        1, 2, 3:  c.mode = CMD_L_REL;
        4:        begin c.mode = CMD_Q_REL; want = 4; end
        5:        c.mode = CMD_T_REL;
        6, 7:     begin c.mode = CMD_C_REL; want = 6; end
        8:        begin c.mode = CMD_S_REL; want = 4; end
        9:        begin c.mode = CMD_Z_REL; want = 0; end
        10:       begin c.mode = CMD_H_REL; want = 1; end
        11:       begin c.mode = CMD_H_ABS; want = 1; end
        12:       begin c.mode = CMD_V_REL; want = 1; end
        13:       begin c.mode = CMD_V_ABS; want = 1; end
        14:       c.mode = CMD_L_ABS;
        15:       c.mode = CMD_M_ABS;
        16:       begin c.mode = CMD_A_REL; want = 6; end
        17:       begin c.mode = CMD_C_ABS; want = 6; end
        default:  begin c.mode = CMD_W'($urandom()); want = $urandom_range(7); end
      endcase
    end
    c.count = ($urandom_range(4) == 0) ? CNT_W'($urandom_range(7)) : CNT_W'(want);
    for (i = 0; i < MAX_ARGS; i++) c.args[i] = rand_coord();
    return c;
  endfunction

  task automatic send_cmd(input path_cmd_t c);
    int i;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    path_start <= c.path_start;
    mode       <= c.mode;
    arg_count  <= c.count;
    for (i = 0; i < MAX_ARGS; i++) arg[i] <= c.args[i];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.add_command(c);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic configure(input logic [SCALE_W-1:0] scale, input logic en,
                           input logic signed [TRIG_W-1:0] cosv,
                           input logic signed [TRIG_W-1:0] sinv);
    wait_drained();
    write_reg(REG_SCALE, CFG_W'(scale));
    write_reg(REG_ROT_EN, CFG_W'(en));
    write_reg(REG_COS, {{(CFG_W-TRIG_W){cosv[TRIG_W-1]}}, cosv});
    write_reg(REG_SIN, {{(CFG_W-TRIG_W){sinv[TRIG_W-1]}}, sinv});
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic run_random(input int unsigned items);
    int unsigned k;
    int unsigned left;
    left = 0;
    for (k = 0; k < items; k++) begin
      send_cmd(rand_cmd(left == 0));
      if (left == 0) left = $urandom_range(12, 1);
      else left--;
    end
  endtask

  task automatic run_directed();
    send_cmd(mk(1, CMD_M_REL, 2, 10 * UNIT, 20 * UNIT, 0, 0, 0, 0));
    send_cmd(mk(0, CMD_L_REL, 2, -3 * UNIT, 5 * UNIT, 0, 0, 0, 0));
    send_cmd(mk(0, CMD_H_REL, 0, UNIT, UNIT, 0, 0, 0, 0));
    send_cmd(mk(0, CMD_V_ABS, 0, UNIT, UNIT, 0, 0, 0, 0));
    send_cmd(mk(0, CMD_H_ABS, 3, 1, 2, 7 * UNIT, 5, 6, 7));
    send_cmd(mk(0, CMD_V_REL, 6, COORD_MAX, COORD_MAX, COORD_MIN, 1, 2, 3));
    send_cmd(mk(0, CMD_H_REL, 6, COORD_MIN, COORD_MIN, COORD_MIN, UNIT, 0, -1));
    send_cmd(mk(0, CMD_Q_REL, 4, UNIT, 2 * UNIT, 3 * UNIT, 4 * UNIT, 9, 9));
    send_cmd(mk(0, CMD_T_REL, 2, -UNIT, -UNIT, 0, 0, 0, 0));
    send_cmd(mk(0, CMD_C_REL, 6, 1, 2, 3, 4, 5, 6));
    send_cmd(mk(0, CMD_S_REL, 4, -7, -8, 9, 10, 11, 12));
    send_cmd(mk(0, CMD_Z_REL, 0, UNIT, UNIT, 0, 0, 0, 0));
    send_cmd(mk(0, CMD_Z_REL, 2, UNIT, -UNIT, 0, 0, 0, 0));
    send_cmd(mk(0, CMD_L_REL, 3, UNIT, UNIT, 5 * UNIT, 0, 0, 0));
    send_cmd(mk(0, CMD_M_REL, 1, 3 * UNIT, 0, 0, 0, 0, 0));
    send_cmd(mk(0, CMD_C_REL, 7, 1, 2, 3, 4, 5, 6));
    send_cmd(mk(0, CMD_L_ABS, 2, 4 * UNIT, -4 * UNIT, 0, 0, 0, 0));
    send_cmd(mk(0, CMD_A_REL, 6, UNIT, UNIT, 0, 1, 1, 2 * UNIT));
    send_cmd(mk(0, CMD_NUL, 5, 1, 2, 3, 4, 5, 6));
    send_cmd(mk(0, CMD_DEL, 6, -1, -1, -1, -1, -1, -1));
    send_cmd(mk(0, CMD_Z_ABS, 4, COORD_MAX, COORD_MIN, 1, 2, 3, 4));
    send_cmd(mk(0, CMD_L_REL, 2, COORD_MAX, COORD_MAX, 0, 0, 0, 0));
    send_cmd(mk(0, CMD_M_REL, 2, COORD_MIN, COORD_MIN, 0, 0, 0, 0));
    send_cmd(mk(1, CMD_L_REL, 2, COORD_MIN, COORD_MAX, 0, 0, 0, 0));
    send_cmd(mk(0, CMD_V_ABS, 1, COORD_MIN, 0, 0, 0, 0, 0));
    send_cmd(mk(0, CMD_H_ABS, 1, COORD_MAX, 0, 0, 0, 0, 0));
    send_cmd(mk(0, CMD_Z_REL, 5, UNIT, UNIT, UNIT, UNIT, UNIT, UNIT));
  endtask

  task automatic configure_random();
    logic [SCALE_W-1:0] scale;
    scale = ($urandom_range(3) == 0) ? SCALE_W'($urandom())
                                     : SCALE_W'($urandom_range(24'h02_0000, 24'h00_4000));
    configure(scale, 1'($urandom()), TRIG_W'(int'($urandom_range(32768)) - 16384),
              TRIG_W'(int'($urandom_range(32768)) - 16384));
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random(80);

    configure(24'hff_ffff, 1'b1, 16'sd16384, 16'sd0);
    run_random(50);
    configure(24'h01_0000, 1'b1, -16'sd16384, 16'sd16384);
    run_random(50);
    configure(24'h00_0001, 1'b1, 16'sd0, -16'sd16384);
    run_random(30);
    // hold off until the block is empty, then resume mid-setting
    wait_drained();
    run_random(30);

    configure(24'h00_0000, 1'b1, 16'sd11585, 16'sd11585);
    quiet <= 1'b1;
    run_random(80);
    quiet <= 1'b0;

    repeat (3) begin
      configure_random();
      run_random(60);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run: %0d commands under %0d register settings, %0d results compared,",
             sent, settings, sb.compared);
    $display("with relative, h/v, odd-count, clamped-count and saturating cases included.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
